### hdl/floor_ceiling_texture_caster_macros.svh
// Assertion macros used by the caster back end.
`ifndef FLOOR_CEILING_TEXTURE_CASTER_MACROS_SVH
`define FLOOR_CEILING_TEXTURE_CASTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/fcc_pkg.sv
// Shared constants, types and state encodings of the floor and ceiling caster.
package fcc_pkg;

	localparam int TEX_SIZE    = 64;
	localparam int TEX_BITS    = $clog2(TEX_SIZE);
	localparam int TEX_ADDR_W  = 2 * TEX_BITS;
	localparam int TEX_ENTRIES = TEX_SIZE * TEX_SIZE;
	localparam int SCREEN_BITS = 12;
	localparam int FRAC_BITS   = 16;

	localparam int POS_W    = 32;
	localparam int PLAYER_W = 24;
	localparam int VEC_W    = 16;
	localparam int VEC_FRAC = 14;
	localparam int DIM_W    = 13;
	localparam int ROW_W    = SCREEN_BITS;
	localparam int IDX_W    = 12;
	localparam int COLOR_W  = 24;
	localparam int CH_W     = 8;
	localparam int FOG_W    = 16;

	localparam logic [FOG_W-1:0] FOG_LIMIT = 16'd384;

	// Row setup arithmetic widths
	localparam int RD_W   = DIM_W + FRAC_BITS;
	localparam int PROD_W = RD_W + VEC_W + 1;
	localparam int DIV_W  = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// Command queue
	localparam int QDEPTH = 2;

	// Input op codes
	localparam logic [1:0] OP_LOAD_FLOOR = 2'd0;
	localparam logic [1:0] OP_LOAD_CEIL  = 2'd1;
	localparam logic [1:0] OP_DRAW       = 2'd2;

	// Register indexes
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int APB_ADDR_W = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_PLAYER_X       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PLAYER_Y       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_DIR_X     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VIEW_DIR_Y     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_PLANE_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_PLANE_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd7;

	// Register reset values
	localparam logic signed [VEC_W-1:0] DIR_X_RST   = 16'sd16384;
	localparam logic signed [VEC_W-1:0] DIR_Y_RST   = 16'sd0;
	localparam logic signed [VEC_W-1:0] PLANE_X_RST = 16'sd0;
	localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 16'sd10813;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;

	typedef enum logic [1:0] {
		KIND_LOAD_FLOOR,
		KIND_LOAD_CEIL,
		KIND_DRAW
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [COLOR_W-1:0] color;
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  col;
		logic [FOG_W-1:0]  fog;
	} cmd_t;

	typedef struct packed {
		logic [PLAYER_W-1:0]     player_x;
		logic [PLAYER_W-1:0]     player_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
		logic [DIM_W-1:0]        height;
		logic [DIM_W-1:0]        width;
	} view_cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] step_x;
		logic [POS_W-1:0] step_y;
		logic             saturated;
	} row_setup_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROW,
		B_FETCH,
		B_SHADE,
		B_FOG,
		B_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		RC_IDLE,
		RC_DIVR,
		RC_MUL,
		RC_USE,
		RC_DIVS,
		RC_DONE
	} rc_state_t;

endpackage

### hdl/fcc_front.sv
// Front end: accepts input words, decodes the op and queues commands.
module fcc_front
	import fcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [IDX_W-1:0]   texel_index,
	input  logic [COLOR_W-1:0] texel_color,
	input  logic [ROW_W-1:0]   pixel_row,
	input  logic [ROW_W-1:0]   pixel_column,
	input  logic [FOG_W-1:0]   row_fog_distance,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             accept, push, known;
	cmd_kind_t        kind;

	// Decode the op; unknown codes are taken and dropped
	always_comb begin
		known = 1'b1;
		kind  = KIND_DRAW;
		unique case (op)
			OP_LOAD_FLOOR: kind = KIND_LOAD_FLOOR;
			OP_LOAD_CEIL:  kind = KIND_LOAD_CEIL;
			OP_DRAW:       kind = KIND_DRAW;
			default:       known = 1'b0;
		endcase
	end

	assign in_ready  = (count_q != CNT_W'(QDEPTH));
	assign accept    = in_valid && in_ready;
	assign push      = accept && known;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// Store queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: kind, idx: texel_index, color: texel_color,
				row: pixel_row, col: pixel_column, fog: row_fog_distance};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'((32'(wr_ptr_q) + 1) % QDEPTH);
			end
			if (cmd_pop) begin
				rd_ptr_q <= PTR_W'((32'(rd_ptr_q) + 1) % QDEPTH);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/fcc_rowcalc.sv
// Row setup: row distance, start position and per-column step, one shared divider.
module fcc_rowcalc
	import fcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ROW_W-1:0] row,
	input  view_cfg_t        cfg,
	output logic             done,
	output row_setup_t       setup
);

	rc_state_t state_q, state_d;

	logic signed [RD_W-1:0]   rowdist_q;
	logic signed [PROD_W-1:0] prod_q, prod_d, prod_adj;
	logic [PROD_W-1:0]        prod_mag;
	logic signed [VEC_W:0]    mul_op;
	logic [1:0]               mi_q;
	row_setup_t               setup_q;

	logic [DIV_W-1:0]     dvd_q, dvd_nx, quot_signed;
	logic [DIM_W-1:0]     rem_q, rem_nx, dvs_q, w_eff;
	logic [DIM_W:0]       rem_sh;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q, ge;

	logic signed [DIM_W:0] p, p_abs;
	logic [DIV_W-1:0]      posz;

	// Row offset from the horizon and camera height
	always_comb begin
		p     = $signed({2'b00, row}) - $signed({2'b00, cfg.height[DIM_W-1:1]});
		p_abs = p[DIM_W] ? -p : p;
		posz  = DIV_W'({cfg.height, {(FRAC_BITS-1){1'b0}}});
		w_eff = (cfg.width == '0) ? DIM_W'(1) : cfg.width;
	end

	// One restoring divide step
	always_comb begin
		rem_sh      = {rem_q, dvd_q[DIV_W-1]};
		ge          = (rem_sh >= {1'b0, dvs_q});
		rem_nx      = ge ? DIM_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIM_W-1:0];
		dvd_nx      = {dvd_q[DIV_W-2:0], ge};
		quot_signed = neg_q ? -dvd_q : dvd_q;
	end

	// Select the multiplier operand
	always_comb begin
		case (mi_q)
			2'd0:    mul_op = {cfg.dir_x[VEC_W-1], cfg.dir_x} - {cfg.plane_x[VEC_W-1], cfg.plane_x};
			2'd1:    mul_op = {cfg.dir_y[VEC_W-1], cfg.dir_y} - {cfg.plane_y[VEC_W-1], cfg.plane_y};
			2'd2:    mul_op = {cfg.plane_x, 1'b0};
			default: mul_op = {cfg.plane_y, 1'b0};
		endcase
		prod_d   = rowdist_q * mul_op;
		prod_adj = prod_q + $signed({{(PROD_W-VEC_FRAC){1'b0}}, {VEC_FRAC{prod_q[PROD_W-1]}}});
		prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			RC_IDLE: begin
				if (start) begin
					state_d = (p == '0) ? RC_MUL : RC_DIVR;
				end
			end
			RC_DIVR: begin
				if (cnt_q == '0) begin
					state_d = RC_MUL;
				end
			end
			RC_MUL: state_d = RC_USE;
			RC_USE: state_d = mi_q[1] ? RC_DIVS : RC_MUL;
			RC_DIVS: begin
				if (cnt_q == '0) begin
					state_d = (mi_q == 2'd3) ? RC_DONE : RC_MUL;
				end
			end
			RC_DONE: state_d = RC_IDLE;
			default: state_d = RC_IDLE;
		endcase
	end

	assign done  = (state_q == RC_DONE);
	assign setup = setup_q;

	// Datapath: divide, multiply and accumulate results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q   <= '0;
			mi_q      <= '0;
			cnt_q     <= '0;
			rowdist_q <= '0;
			prod_q    <= '0;
			dvd_q     <= '0;
			dvs_q     <= '0;
			rem_q     <= '0;
			neg_q     <= 1'b0;
		end else begin
			case (state_q)
				RC_IDLE: begin
					if (start) begin
						mi_q              <= '0;
						setup_q.saturated <= (p == '0);
						rowdist_q         <= $signed(posz[RD_W-1:0]);
						dvd_q             <= posz;
						dvs_q             <= p_abs[DIM_W-1:0];
						rem_q             <= '0;
						neg_q             <= p[DIM_W];
						cnt_q             <= DIV_CNT_W'(DIV_W);
					end
				end
				RC_DIVR: begin
					if (cnt_q != '0) begin
						rem_q <= rem_nx;
						dvd_q <= dvd_nx;
						cnt_q <= cnt_q - DIV_CNT_W'(1);
					end else begin
						rowdist_q <= $signed(quot_signed[RD_W-1:0]);
					end
				end
				RC_MUL: prod_q <= prod_d;
				RC_USE: begin
					case (mi_q)
						2'd0: setup_q.pos_x <= POS_W'(cfg.player_x) + prod_adj[PROD_W-1:VEC_FRAC];
						2'd1: setup_q.pos_y <= POS_W'(cfg.player_y) + prod_adj[PROD_W-1:VEC_FRAC];
						default: begin
							dvd_q <= DIV_W'(prod_mag[PROD_W-1:VEC_FRAC]);
							dvs_q <= w_eff;
							rem_q <= '0;
							neg_q <= prod_q[PROD_W-1];
							cnt_q <= DIV_CNT_W'(DIV_W);
						end
					endcase
					if (!mi_q[1]) begin
						mi_q <= mi_q + 2'd1;
					end
				end
				RC_DIVS: begin
					if (cnt_q != '0) begin
						rem_q <= rem_nx;
						dvd_q <= dvd_nx;
						cnt_q <= cnt_q - DIV_CNT_W'(1);
					end else begin
						if (mi_q == 2'd2) begin
							setup_q.step_x <= quot_signed;
						end else begin
							setup_q.step_y <= quot_signed;
						end
						mi_q <= mi_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### hdl/fcc_fog.sv
// Fog shading: six channel divisions by the fog distance, one quotient bit per cycle.
module fcc_fog
	import fcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COLOR_W-1:0] floor_in,
	input  logic [COLOR_W-1:0] ceil_in,
	input  logic [FOG_W-1:0]   fog,
	output logic               done,
	output logic [COLOR_W-1:0] floor_out,
	output logic [COLOR_W-1:0] ceil_out
);

	localparam int LANES = 6;
	localparam int NUM_W = CH_W + 9;
	localparam int DSH_W = FOG_W + CH_W - 1;
	localparam int CNT_W = $clog2(CH_W + 1);

	logic [NUM_W-1:0]   rem_q [LANES];
	logic [CH_W-1:0]    quo_q [LANES];
	logic [CH_W-1:0]    chan  [LANES];
	logic [DSH_W-1:0]   dsh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q, bypass_q;
	logic [COLOR_W-1:0] floor_q, ceil_q;

	// Split both texels into channels
	always_comb begin
		chan[0] = floor_in[23:16];
		chan[1] = floor_in[15:8];
		chan[2] = floor_in[7:0];
		chan[3] = ceil_in[23:16];
		chan[4] = ceil_in[15:8];
		chan[5] = ceil_in[7:0];
	end

	// Lane datapath: compare, subtract, shift in a quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= NUM_W'(chan[l]) * NUM_W'(FOG_LIMIT);
				quo_q[l] <= '0;
			end
			dsh_q    <= {fog, {(CH_W-1){1'b0}}};
			bypass_q <= (fog <= FOG_LIMIT);
			floor_q  <= floor_in;
			ceil_q   <= ceil_in;
		end else if (busy_q) begin
			for (int l = 0; l < LANES; l++) begin
				if (DSH_W'(rem_q[l]) >= dsh_q) begin
					rem_q[l] <= NUM_W'(DSH_W'(rem_q[l]) - dsh_q);
					quo_q[l] <= {quo_q[l][CH_W-2:0], 1'b1};
				end else begin
					quo_q[l] <= {quo_q[l][CH_W-2:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CH_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign floor_out = bypass_q ? floor_q : {quo_q[0], quo_q[1], quo_q[2]};
	assign ceil_out  = bypass_q ? ceil_q : {quo_q[3], quo_q[4], quo_q[5]};

endmodule

### hdl/fcc_back.sv
// Back end: texture memories, pixel sequencer, world position and output register.
`include "floor_ceiling_texture_caster_macros.svh"
module fcc_back
	import fcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	input  view_cfg_t          cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] floor_color,
	output logic [COLOR_W-1:0] ceiling_color,
	output logic [ROW_W-1:0]   floor_row_out,
	output logic [ROW_W-1:0]   ceiling_row_out,
	output logic [ROW_W-1:0]   column_out,
	output logic               horizon_saturated
);

	back_state_t state_q, state_d;

	logic [COLOR_W-1:0] floor_mem [TEX_ENTRIES];
	logic [COLOR_W-1:0] ceil_mem  [TEX_ENTRIES];
	logic [COLOR_W-1:0] floor_rd_q, ceil_rd_q;
	logic [TEX_ADDR_W-1:0] rd_addr;
	logic floor_we, ceil_we, rd_en;

	logic [POS_W-1:0] pos_x_q, pos_y_q, step_x_q, step_y_q;
	logic             sat_q;
	logic [ROW_W-1:0] row_q, col_q;
	logic [FOG_W-1:0] fog_q;
	logic [DIM_W-1:0] ceil_row;

	logic       rc_start, rc_done;
	row_setup_t rc_setup;
	logic       fog_start, fog_done;
	logic [COLOR_W-1:0] fog_floor, fog_ceil;

	logic out_valid_q, out_load;

	fcc_rowcalc u_rowcalc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rc_start),
		.row    (cmd.row),
		.cfg    (cfg),
		.done   (rc_done),
		.setup  (rc_setup)
	);

	fcc_fog u_fog (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (fog_start),
		.floor_in  (floor_rd_q),
		.ceil_in   (ceil_rd_q),
		.fog       (fog_q),
		.done      (fog_done),
		.floor_out (fog_floor),
		.ceil_out  (fog_ceil)
	);

	assign cmd_pop   = (state_q == B_IDLE) && cmd_valid;
	assign floor_we  = cmd_pop && (cmd.kind == KIND_LOAD_FLOOR);
	assign ceil_we   = cmd_pop && (cmd.kind == KIND_LOAD_CEIL);
	assign rc_start  = cmd_pop && (cmd.kind == KIND_DRAW) && (cmd.col == '0);
	assign rd_en     = (state_q == B_FETCH);
	assign fog_start = (state_q == B_SHADE);
	assign out_load  = (state_q == B_OUT) && (!out_valid_q || out_ready);
	assign rd_addr   = {pos_y_q[FRAC_BITS-1 -: TEX_BITS], pos_x_q[FRAC_BITS-1 -: TEX_BITS]};
	assign ceil_row  = cfg.height - DIM_W'(row_q) - DIM_W'(1);

	// Texture writes
	always_ff @(posedge clk) begin
		if (floor_we) begin
			floor_mem[cmd.idx[TEX_ADDR_W-1:0]] <= cmd.color;
		end
		if (ceil_we) begin
			ceil_mem[cmd.idx[TEX_ADDR_W-1:0]] <= cmd.color;
		end
	end

	// Texture reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			floor_rd_q <= floor_mem[rd_addr];
			ceil_rd_q  <= ceil_mem[rd_addr];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_pop && (cmd.kind == KIND_DRAW)) begin
					state_d = (cmd.col == '0) ? B_ROW : B_FETCH;
				end
			end
			B_ROW: begin
				if (rc_done) begin
					state_d = B_FETCH;
				end
			end
			B_FETCH: state_d = B_SHADE;
			B_SHADE: state_d = B_FOG;
			B_FOG: begin
				if (fog_done) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (out_load) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Hold the draw item
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			row_q <= cmd.row;
			col_q <= cmd.col;
			fog_q <= cmd.fog;
		end
	end

	// World position, step and saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			sat_q    <= 1'b0;
		end else if ((state_q == B_ROW) && rc_done) begin
			pos_x_q  <= rc_setup.pos_x;
			pos_y_q  <= rc_setup.pos_y;
			step_x_q <= rc_setup.step_x;
			step_y_q <= rc_setup.step_y;
			sat_q    <= rc_setup.saturated;
		end else if (rd_en) begin
			pos_x_q <= pos_x_q + step_x_q;
			pos_y_q <= pos_y_q + step_y_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			floor_color       <= fog_floor;
			ceiling_color     <= fog_ceil;
			floor_row_out     <= row_q;
			ceiling_row_out   <= ceil_row[ROW_W-1:0];
			column_out        <= col_q;
			horizon_saturated <= sat_q;
		end
	end

	assign out_valid = out_valid_q;

	`FCC_ASSERT_NOW(a_rc_done_in_row, rc_done, state_q == B_ROW, "row setup finished outside row wait")
	`FCC_ASSERT_NOW(a_fog_done_in_fog, fog_done, state_q == B_FOG, "fog result outside fog wait")
	`FCC_ASSERT_NEXT(a_fetch_then_shade, state_q == B_FETCH, state_q == B_SHADE, "fetch not followed by shade")
	`FCC_ASSERT_NEXT(a_load_shows_word, out_load, out_valid_q, "loaded result word not presented")

endmodule

### hdl/floor_ceiling_texture_caster.sv
// Floor and ceiling texture caster. A load word writes one texel of the floor or ceiling
// texture. A draw word at a non-zero column runs a texel fetch, then a fog unit that
// divides six channels at one quotient bit per cycle (8 bits). A draw word at column 0
// first runs row setup, in which the horizon row skips the row distance divide: a 32-step
// restoring divider computes the row distance and then both per-column steps, with four
// multiplies in between. Input words queue in a two-deep command queue, and results
// leave through an output register, so either side may stall independently.
module floor_ceiling_texture_caster
	import fcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [IDX_W-1:0]      texel_index,
	input  logic [COLOR_W-1:0]    texel_color,
	input  logic [ROW_W-1:0]      pixel_row,
	input  logic [ROW_W-1:0]      pixel_column,
	input  logic [FOG_W-1:0]      row_fog_distance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COLOR_W-1:0]    floor_color,
	output logic [COLOR_W-1:0]    ceiling_color,
	output logic [ROW_W-1:0]      floor_row_out,
	output logic [ROW_W-1:0]      ceiling_row_out,
	output logic [ROW_W-1:0]      column_out,
	output logic                  horizon_saturated
);

	view_cfg_t cfg_q;
	logic      wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic      cmd_valid, cmd_pop;
	cmd_t      cmd;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_x <= '0;
			cfg_q.player_y <= '0;
			cfg_q.dir_x    <= DIR_X_RST;
			cfg_q.dir_y    <= DIR_Y_RST;
			cfg_q.plane_x  <= PLANE_X_RST;
			cfg_q.plane_y  <= PLANE_Y_RST;
			cfg_q.height   <= HEIGHT_RST;
			cfg_q.width    <= WIDTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PLAYER_X:       cfg_q.player_x <= pwdata[PLAYER_W-1:0];
				REG_PLAYER_Y:       cfg_q.player_y <= pwdata[PLAYER_W-1:0];
				REG_VIEW_DIR_X:     cfg_q.dir_x    <= $signed(pwdata[VEC_W-1:0]);
				REG_VIEW_DIR_Y:     cfg_q.dir_y    <= $signed(pwdata[VEC_W-1:0]);
				REG_CAMERA_PLANE_X: cfg_q.plane_x  <= $signed(pwdata[VEC_W-1:0]);
				REG_CAMERA_PLANE_Y: cfg_q.plane_y  <= $signed(pwdata[VEC_W-1:0]);
				REG_SCREEN_HEIGHT:  cfg_q.height   <= pwdata[DIM_W-1:0];
				REG_SCREEN_WIDTH:   cfg_q.width    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read mux
	always_comb begin
		unique case (reg_idx)
			REG_PLAYER_X:       prdata = 32'(cfg_q.player_x);
			REG_PLAYER_Y:       prdata = 32'(cfg_q.player_y);
			REG_VIEW_DIR_X:     prdata = 32'($unsigned(cfg_q.dir_x));
			REG_VIEW_DIR_Y:     prdata = 32'($unsigned(cfg_q.dir_y));
			REG_CAMERA_PLANE_X: prdata = 32'($unsigned(cfg_q.plane_x));
			REG_CAMERA_PLANE_Y: prdata = 32'($unsigned(cfg_q.plane_y));
			REG_SCREEN_HEIGHT:  prdata = 32'(cfg_q.height);
			REG_SCREEN_WIDTH:   prdata = 32'(cfg_q.width);
			default:            prdata = '0;
		endcase
	end

	fcc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.texel_index      (texel_index),
		.texel_color      (texel_color),
		.pixel_row        (pixel_row),
		.pixel_column     (pixel_column),
		.row_fog_distance (row_fog_distance),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop)
	);

	fcc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop),
		.cfg               (cfg_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.floor_color       (floor_color),
		.ceiling_color     (ceiling_color),
		.floor_row_out     (floor_row_out),
		.ceiling_row_out   (ceiling_row_out),
		.column_out        (column_out),
		.horizon_saturated (horizon_saturated)
	);

endmodule

### bench/tb_floor_ceiling_texture_caster.sv
// Self-checking testbench for the floor and ceiling texture caster.
module tb_floor_ceiling_texture_caster;
	import fcc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  SETTLE = 300;
	localparam longint LIMIT = 3000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [COLOR_W-1:0] floor_c;
		logic [COLOR_W-1:0] ceil_c;
		logic [ROW_W-1:0]   frow;
		logic [ROW_W-1:0]   crow;
		logic [ROW_W-1:0]   col;
		logic               sat;
	} pixel_t;

	// Directed stimulus row; typed-in row checks only where obvious
	typedef struct {
		logic [1:0]         op;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
		logic [ROW_W-1:0]   row;
		logic [ROW_W-1:0]   col;
		logic [FOG_W-1:0]   fog;
		bit                 typed;
		logic [ROW_W-1:0]   crow;
		logic               sat;
	} word_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [IDX_W-1:0] texel_index = '0;
	logic [COLOR_W-1:0] texel_color = '0;
	logic [ROW_W-1:0] pixel_row = '0, pixel_column = '0;
	logic [FOG_W-1:0] row_fog_distance = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [COLOR_W-1:0] floor_color, ceiling_color;
	logic [ROW_W-1:0] floor_row_out, ceiling_row_out, column_out;
	logic horizon_saturated;

	floor_ceiling_texture_caster u_dut (.*);

	always #4 clk = ~clk;

	// Predictor copy of registers and state
	logic [PLAYER_W-1:0] v_px, v_py;
	logic signed [VEC_W-1:0] v_dx, v_dy, v_plx, v_ply;
	logic [DIM_W-1:0] v_h, v_w;
	logic [POS_W-1:0] pos_x, pos_y, step_x, step_y;
	logic row_sat;
	logic [COLOR_W-1:0] floor_tex [TEX_ENTRIES];
	logic [COLOR_W-1:0] ceil_tex [TEX_ENTRIES];
	bit floor_wr [TEX_ENTRIES];
	bit ceil_wr [TEX_ENTRIES];

	pixel_t expected_pixels[$];
	int errors = 0;
	longint cycles = 0;
	bit tx_quiet = 0, rx_quiet = 0;
	int hold_req = 0;

	function automatic logic [COLOR_W-1:0] fog_shade(logic [COLOR_W-1:0] c,
			logic [FOG_W-1:0] d);
		logic [COLOR_W-1:0] r;
		if (d <= FOG_LIMIT)
			return c;
		for (int k = 0; k < 3; k++)
			r[k*CH_W +: CH_W] = CH_W'((32'(c[k*CH_W +: CH_W]) * 32'(FOG_LIMIT)) / 32'(d));
		return r;
	endfunction

	// Work out row distance, start position and per-column step
	task automatic start_row(logic [ROW_W-1:0] row);
		longint h, p, posz, rdist, w;
		h = longint'(v_h);
		p = longint'(row) - h / 2;
		posz = h <<< (FRAC_BITS - 1);
		w = (v_w != 0) ? longint'(v_w) : 1;
		if (p == 0) begin
			rdist = posz;
			row_sat = 1;
		end else begin
			rdist = posz / p;
			row_sat = 0;
		end
		step_x = POS_W'((rdist * (2 * longint'(v_plx))) / (w * 16384));
		step_y = POS_W'((rdist * (2 * longint'(v_ply))) / (w * 16384));
		pos_x = POS_W'(longint'(v_px) + (rdist * (longint'(v_dx) - longint'(v_plx))) / 16384);
		pos_y = POS_W'(longint'(v_py) + (rdist * (longint'(v_dy) - longint'(v_ply))) / 16384);
	endtask

	// One word over the input handshake, then maybe a random gap
	task automatic send_raw(logic [1:0] o, logic [IDX_W-1:0] i, logic [COLOR_W-1:0] c,
			logic [ROW_W-1:0] r, logic [ROW_W-1:0] cl, logic [FOG_W-1:0] f);
		in_valid <= 1;
		op <= o;
		texel_index <= i;
		texel_color <= c;
		pixel_row <= r;
		pixel_column <= cl;
		row_fog_distance <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (!tx_quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic load_texel(logic [1:0] o, logic [IDX_W-1:0] i, logic [COLOR_W-1:0] c);
		if (o == OP_LOAD_FLOOR) begin
			floor_tex[i] = c;
			floor_wr[i] = 1;
		end else if (o == OP_LOAD_CEIL) begin
			ceil_tex[i] = c;
			ceil_wr[i] = 1;
		end
		send_raw(o, i, c, ROW_W'($urandom), ROW_W'($urandom), FOG_W'($urandom));
	endtask

	task automatic draw_pixel(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
			logic [FOG_W-1:0] fog, bit typed, logic [ROW_W-1:0] crow, logic sat);
		logic [IDX_W-1:0] addr;
		pixel_t px;
		if (col == 0)
			start_row(row);
		addr = {pos_y[FRAC_BITS-1 -: TEX_BITS], pos_x[FRAC_BITS-1 -: TEX_BITS]};
		// Write any texel still undefined before it is read
		if (!floor_wr[addr])
			load_texel(OP_LOAD_FLOOR, addr, COLOR_W'($urandom));
		if (!ceil_wr[addr])
			load_texel(OP_LOAD_CEIL, addr, COLOR_W'($urandom));
		px.floor_c = fog_shade(floor_tex[addr], fog);
		px.ceil_c = fog_shade(ceil_tex[addr], fog);
		px.frow = row;
		px.crow = ROW_W'(32'(v_h) - 32'(row) - 1);
		px.col = col;
		px.sat = row_sat;
		if (typed) begin
			px.crow = crow;
			px.sat = sat;
		end
		pos_x = pos_x + step_x;
		pos_y = pos_y + step_y;
		expected_pixels.push_back(px);
		send_raw(OP_DRAW, IDX_W'($urandom), COLOR_W'($urandom), row, col, fog);
	endtask

	task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
		case (idx)
			REG_PLAYER_X:       v_px = v[PLAYER_W-1:0];
			REG_PLAYER_Y:       v_py = v[PLAYER_W-1:0];
			REG_VIEW_DIR_X:     v_dx = v[VEC_W-1:0];
			REG_VIEW_DIR_Y:     v_dy = v[VEC_W-1:0];
			REG_CAMERA_PLANE_X: v_plx = v[VEC_W-1:0];
			REG_CAMERA_PLANE_Y: v_ply = v[VEC_W-1:0];
			REG_SCREEN_HEIGHT:  v_h = v[DIM_W-1:0];
			default:            v_w = v[DIM_W-1:0];
		endcase
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= APB_ADDR_W'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic set_view(logic [31:0] px, logic [31:0] py, logic [31:0] dx,
			logic [31:0] dy, logic [31:0] plx, logic [31:0] ply, logic [31:0] h,
			logic [31:0] w);
		cfg_write(REG_PLAYER_X, px);
		cfg_write(REG_PLAYER_Y, py);
		cfg_write(REG_VIEW_DIR_X, dx);
		cfg_write(REG_VIEW_DIR_Y, dy);
		cfg_write(REG_CAMERA_PLANE_X, plx);
		cfg_write(REG_CAMERA_PLANE_Y, ply);
		cfg_write(REG_SCREEN_HEIGHT, h);
		cfg_write(REG_SCREEN_WIDTH, w);
	endtask

	// Drop valid and wait for every pending pixel plus the block's tail latency
	task automatic wait_drain();
		in_valid <= 0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_words(int n);
		int cnt;
		int kind;
		int span;
		logic [ROW_W-1:0] row;
		logic [FOG_W-1:0] fog;
		cnt = 0;
		while (cnt < n) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				load_texel(2'($urandom_range(0, 1)), IDX_W'($urandom), COLOR_W'($urandom));
			end else if (kind == 1) begin
				send_raw(OP_UNUSED, IDX_W'($urandom), COLOR_W'($urandom), ROW_W'($urandom),
					ROW_W'($urandom), FOG_W'($urandom));
			end else if (kind == 2) begin
				draw_pixel(ROW_W'($urandom), ROW_W'($urandom), FOG_W'($urandom), 1'b0, '0, 1'b0);
				cnt++;
			end else begin
				// Well-formed row: column 0 then a run of columns
				if ($urandom_range(0, 4) == 0)
					row = ROW_W'(v_h / 2);
				else
					row = ROW_W'($urandom_range(0, (v_h > 1) ? v_h - 1 : 0));
				fog = ($urandom_range(0, 1) != 0) ? FOG_W'($urandom_range(0, 600))
					: FOG_W'($urandom);
				span = $urandom_range(1, 8);
				for (int c = 0; c < span; c++)
					draw_pixel(row, ROW_W'(c), fog, 1'b0, '0, 1'b0);
				cnt += span;
			end
		end
	endtask

	word_row_t directed[$] = '{
		'{OP_LOAD_FLOOR, 12'd0, 24'hFFFFFF, 12'd0, 12'd0, 16'd0, 0, 12'd0, 1'b0},
		'{OP_LOAD_CEIL, 12'd0, 24'h000000, 12'd0, 12'd0, 16'd0, 0, 12'd0, 1'b0},
		'{OP_LOAD_FLOOR, 12'd4095, 24'h000000, 12'hFFF, 12'hFFF, 16'hFFFF, 0, 12'd0, 1'b0},
		'{OP_LOAD_CEIL, 12'd4095, 24'hFFFFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 0, 12'd0, 1'b0},
		'{OP_UNUSED, 12'hFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 0, 12'd0, 1'b0},
		// column without a row start uses the reset position
		'{OP_DRAW, 12'd0, 24'd0, 12'd7, 12'd5, 16'd0, 1, 12'd472, 1'b0},
		// horizon row saturates and stays flagged along the row
		'{OP_DRAW, 12'd0, 24'd0, 12'd240, 12'd0, 16'd384, 1, 12'd239, 1'b1},
		'{OP_DRAW, 12'd0, 24'd0, 12'd240, 12'd1, 16'd385, 1, 12'd239, 1'b1},
		'{OP_DRAW, 12'd0, 24'd0, 12'd240, 12'd2, 16'hFFFF, 1, 12'd239, 1'b1},
		'{OP_DRAW, 12'd0, 24'd0, 12'd479, 12'd0, 16'd0, 1, 12'd0, 1'b0},
		'{OP_DRAW, 12'd0, 24'd0, 12'd479, 12'd1, 16'd1000, 0, 12'd0, 1'b0},
		// above the horizon the row distance goes negative
		'{OP_DRAW, 12'd0, 24'd0, 12'd0, 12'd0, 16'd500, 1, 12'd479, 1'b0},
		'{OP_DRAW, 12'd0, 24'd0, 12'd0, 12'd4095, 16'd384, 0, 12'd0, 1'b0},
		// row past the screen wraps the mirrored row
		'{OP_DRAW, 12'd0, 24'd0, 12'd4095, 12'd0, 16'd0, 1, 12'd480, 1'b0},
		'{OP_DRAW, 12'd0, 24'd0, 12'd300, 12'd0, 16'd65535, 0, 12'd0, 1'b0},
		'{OP_DRAW, 12'd0, 24'd0, 12'd300, 12'd1, 16'd385, 0, 12'd0, 1'b0}
	};

	// Check each accepted pixel against the oldest expectation
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel, got floor %h ceiling %h", $realtime,
					floor_color, ceiling_color);
				errors++;
			end else begin
				e = expected_pixels.pop_front();
				if (e.floor_c !== floor_color || e.ceil_c !== ceiling_color
						|| e.frow !== floor_row_out || e.crow !== ceiling_row_out
						|| e.col !== column_out || e.sat !== horizon_saturated) begin
					$display("%0t: pixel mismatch expected %h %h %0d %0d %0d %b",
						$realtime, e.floor_c, e.ceil_c, e.frow, e.crow, e.col, e.sat);
					$display("%0t:                  actual %h %h %0d %0d %0d %b",
						$realtime, floor_color, ceiling_color, floor_row_out,
						ceiling_row_out, column_out, horizon_saturated);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls, long hold-offs on request
	initial begin
		int n;
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				out_ready <= 0;
				repeat (n) @(posedge clk);
			end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_ready <= 1;
				@(posedge clk);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		word_row_t w;
		v_px = '0;
		v_py = '0;
		v_dx = DIR_X_RST;
		v_dy = DIR_Y_RST;
		v_plx = PLANE_X_RST;
		v_ply = PLANE_Y_RST;
		v_h = HEIGHT_RST;
		v_w = WIDTH_RST;
		pos_x = '0;
		pos_y = '0;
		step_x = '0;
		step_y = '0;
		row_sat = 0;
		foreach (floor_wr[i]) begin
			floor_wr[i] = 0;
			ceil_wr[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed words at reset settings
		foreach (directed[i]) begin
			w = directed[i];
			if (w.op == OP_DRAW)
				draw_pixel(w.row, w.col, w.fog, w.typed, w.crow, w.sat);
			else if (w.op == OP_UNUSED)
				send_raw(w.op, w.idx, w.color, w.row, w.col, w.fog);
			else
				load_texel(w.op, w.idx, w.color);
		end
		wait_drain();

		// Extreme settings
		set_view(32'hFFFFFF, 32'hFFFFFF, 32'h8000, 32'h8000, 32'h7FFF, 32'h7FFF, 2, 1);
		random_words(20);
		wait_drain();
		set_view(0, 0, 32'h7FFF, 32'h7FFF, 32'h8000, 32'h8000, 4096, 4096);
		random_words(20);
		wait_drain();
		// Zero width divides the step by one
		set_view(32'h123456, 32'h0ABCDE, 32'h4000, 32'h0000, 32'h0000, 32'h2A3D, 480, 0);
		random_words(15);
		wait_drain();

		// Fill the queue against a long receiver hold-off
		set_view(32'h080000, 32'h080000, 32'h4000, 32'h0000, 32'h0000, 32'h2A3D, 64, 64);
		hold_req = 400;
		draw_pixel(12'd40, 12'd0, 16'd200, 1'b0, '0, 1'b0);
		for (int c = 1; c < 20; c++)
			draw_pixel(12'd40, ROW_W'(c), 16'd900, 1'b0, '0, 1'b0);
		wait_drain();

		// Random settings, random words
		for (int ph = 0; ph < 5; ph++) begin
			set_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096) : $urandom_range(2, 600),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 800));
			random_words(30);
			wait_drain();
		end

		// Closing stretch with no idling on either side
		tx_quiet = 1;
		rx_quiet = 1;
		random_words(30);
		wait_drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/fcc_pkg.sv
hdl/fcc_front.sv
hdl/fcc_rowcalc.sv
hdl/fcc_fog.sv
hdl/fcc_back.sv
hdl/floor_ceiling_texture_caster.sv
bench/tb_floor_ceiling_texture_caster.sv
